// File: design/sdtq_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sdtq_pkg: shared types and constants of the sorted deadline timer queue
// Request modes, result status codes, cell commands and cell status bundle.
// ----------------------------------------------------------------------------
package sdtq_pkg;

	localparam int DEPTH_DEF     = 16;
	localparam int TIME_BITS_DEF = 48;
	localparam int MAX_RESULTS   = 16;

	typedef enum logic [2:0] {
		MODE_ADD        = 3'd0,
		MODE_REM_HANDLE = 3'd1,
		MODE_REM_OWNER  = 3'd2,
		MODE_POP        = 3'd3,
		MODE_POP_DUE    = 3'd4,
		MODE_EXTRACT    = 3'd5,
		MODE_REMAIN     = 3'd6
	} mode_t;

	typedef enum logic [1:0] {
		STAT_OK    = 2'd0,
		STAT_NONE  = 2'd1,
		STAT_DUP   = 2'd2,
		STAT_FULL  = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		CELL_HOLD   = 3'd0,
		CELL_INSERT = 3'd1,
		CELL_REMOVE = 3'd2,
		CELL_SHIFT  = 3'd3,
		CELL_MARK   = 3'd4
	} cell_op_t;

	typedef struct packed {
		logic by_handle;
		logic by_owner;
		logic any;
	} srch_t;

	typedef struct packed {
		logic valid;
		logic ge;
		logic found;
		logic first;
		logic tkn;
		logic hsel;
		logic due;
		logic tk;
	} cell_stat_t;

endpackage
`default_nettype wire

// File: design/sdtq_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sdtq_cell: one slot of the sorted timer chain
// Holds one timer, compares it against the broadcast request keys and moves
// data to or from its neighbors on insert, remove and extract shifts.
// ----------------------------------------------------------------------------
module sdtq_cell #(
	parameter int TIME_BITS = sdtq_pkg::TIME_BITS_DEF,
	parameter bit CAN_TAKE  = 1'b1
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire sdtq_pkg::cell_op_t     op,
	input  wire sdtq_pkg::srch_t        srch,
	input  wire logic [7:0]             key_handle,
	input  wire logic [31:0]            key_owner,
	input  wire logic [TIME_BITS-1:0]   key_deadline,
	input  wire logic [TIME_BITS-1:0]   key_now,
	input  wire sdtq_pkg::cell_stat_t   l_stat,
	input  wire logic [TIME_BITS-1:0]   l_deadline,
	input  wire logic [7:0]             l_handle,
	input  wire logic [31:0]            l_owner,
	input  wire sdtq_pkg::cell_stat_t   r_stat,
	input  wire logic [TIME_BITS-1:0]   r_deadline,
	input  wire logic [7:0]             r_handle,
	input  wire logic [31:0]            r_owner,
	output sdtq_pkg::cell_stat_t        stat,
	output logic [TIME_BITS-1:0]        deadline,
	output logic [7:0]                  handle,
	output logic [31:0]                 owner
);
	import sdtq_pkg::*;

	logic                 valid_q;
	logic                 tk_q;
	logic [TIME_BITS-1:0] deadline_q;
	logic [7:0]           handle_q;
	logic [31:0]          owner_q;
	logic                 hit;
	logic                 ge;
	logic                 due;
	logic                 tkn;

	assign hit = valid_q && ((srch.by_handle && (handle_q == key_handle)) ||
		(srch.by_owner && (owner_q == key_owner)) || srch.any);
	assign ge  = valid_q && (deadline_q <= key_deadline);
	assign due = valid_q && (deadline_q < key_now);
	assign tkn = due && CAN_TAKE;

	assign stat.valid = valid_q;
	assign stat.ge    = ge;
	assign stat.found = l_stat.found | hit;
	assign stat.first = hit & ~l_stat.found;
	assign stat.tkn   = tkn;
	assign stat.hsel  = valid_q & ~tkn & l_stat.tkn;
	assign stat.due   = due;
	assign stat.tk    = tk_q;

	assign deadline = deadline_q;
	assign handle   = handle_q;
	assign owner    = owner_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			tk_q    <= 1'b0;
		end else begin
			case (op)
				CELL_INSERT: begin
					if (!ge)
						valid_q <= l_stat.ge ? 1'b1 : l_stat.valid;
				end
				CELL_REMOVE: begin
					if (stat.found)
						valid_q <= r_stat.valid;
				end
				CELL_SHIFT: begin
					valid_q <= r_stat.valid;
					tk_q    <= r_stat.tk;
				end
				CELL_MARK: begin
					tk_q <= tkn;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (op)
			CELL_INSERT: begin
				if (!ge) begin
					if (l_stat.ge) begin
						deadline_q <= key_deadline;
						handle_q   <= key_handle;
						owner_q    <= key_owner;
					end else begin
						deadline_q <= l_deadline;
						handle_q   <= l_handle;
						owner_q    <= l_owner;
					end
				end
			end
			CELL_REMOVE: begin
				if (stat.found) begin
					deadline_q <= r_deadline;
					handle_q   <= r_handle;
					owner_q    <= r_owner;
				end
			end
			CELL_SHIFT: begin
				deadline_q <= r_deadline;
				handle_q   <= r_handle;
				owner_q    <= r_owner;
			end
			default: ;
		endcase
	end

endmodule
`default_nettype wire

// File: design/sorted_deadline_timer_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sorted_deadline_timer_queue: deadline-sorted timer queue on a cell chain
// Requests enter on the s_ channel, one result per request (several for an
// extract) leave on the m_ channel with m_tlast on the final one.
// ----------------------------------------------------------------------------
// Usage:
//   A request is taken when s_tvalid and s_tready are high. It is evaluated
//   against every cell of the chain in the following cycle, where an insert
//   or a remove also shifts the chain, and its result is loaded into the
//   output register from the response state once that register is free. The
//   next request is taken in the cycle its result is loaded.
//   An extract emits one result per cycle while the output is not stalled,
//   one per due timer (up to 16), shifting the chain by one cell per result,
//   returns to idle as the last result is loaded and can take the next
//   request in the cycle after that.
//   Chain steps set the speed: one evaluate per request, one shift per result.
//   m_tvalid holds with stable data while m_tready is low; the block keeps
//   its request and waits, and takes no new request until its result moves.
//   Reset empties the queue at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
module sorted_deadline_timer_queue #(
	parameter int DEPTH     = sdtq_pkg::DEPTH_DEF,
	parameter int TIME_BITS = sdtq_pkg::TIME_BITS_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic s_tvalid,
	output logic      s_tready,
	// mode, timer_handle, owner_key, deadline, now
	input  wire logic [((43 + 2*TIME_BITS + 7) / 8) * 8 - 1:0] s_tdata,
	output logic      m_tvalid,
	input  wire logic m_tready,
	// status, out_handle, out_owner, out_deadline, remaining, head_valid,
	// head_deadline
	output logic [((43 + 3*TIME_BITS + 7) / 8) * 8 - 1:0] m_tdata,
	output logic      m_tlast
);
	import sdtq_pkg::*;

	localparam int OUT_W    = ((43 + 3*TIME_BITS + 7) / 8) * 8;
	localparam int I_HANDLE = 3;
	localparam int I_OWNER  = 11;
	localparam int I_DL     = 43;
	localparam int I_NOW    = 43 + TIME_BITS;
	localparam int O_HANDLE = 2;
	localparam int O_OWNER  = 10;
	localparam int O_DL     = 42;
	localparam int O_REM    = 42 + TIME_BITS;
	localparam int O_HV     = 42 + 2*TIME_BITS;
	localparam int O_HDL    = 43 + 2*TIME_BITS;

	localparam cell_stat_t LEFT_END  = '{valid: 1'b0, ge: 1'b1, found: 1'b0, first: 1'b0,
		tkn: 1'b1, hsel: 1'b0, due: 1'b0, tk: 1'b0};
	localparam cell_stat_t RIGHT_END = '0;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EVAL,
		ST_RESP,
		ST_EXTRACT
	} state_t;

	state_t               state_q;
	mode_t                mode_s1;
	logic [7:0]           handle_s1;
	logic [31:0]          owner_s1;
	logic [TIME_BITS-1:0] deadline_s1;
	logic [TIME_BITS-1:0] now_s1;

	status_t              res_status_q;
	logic [7:0]           res_handle_q;
	logic [31:0]          res_owner_q;
	logic [TIME_BITS-1:0] res_deadline_q;
	logic                 res_rem_q;
	logic                 hx_valid_q;
	logic [TIME_BITS-1:0] hx_deadline_q;

	logic                 m_tvalid_q;
	logic                 m_tlast_q;
	logic [OUT_W-1:0]     m_tdata_q;

	cell_stat_t           stat [DEPTH];
	cell_stat_t           lstat [DEPTH];
	cell_stat_t           rstat [DEPTH];
	logic [TIME_BITS-1:0] cell_dl [DEPTH];
	logic [7:0]           cell_hd [DEPTH];
	logic [31:0]          cell_ow [DEPTH];
	logic [TIME_BITS-1:0] l_dl [DEPTH];
	logic [7:0]           l_hd [DEPTH];
	logic [31:0]          l_ow [DEPTH];
	logic [TIME_BITS-1:0] r_dl [DEPTH];
	logic [7:0]           r_hd [DEPTH];
	logic [31:0]          r_ow [DEPTH];

	srch_t                srch;
	cell_op_t             cell_op;
	cell_op_t             eval_op;
	status_t              eval_status;
	logic                 eval_has;
	logic                 eval_rem;
	logic                 eval_extract;
	logic                 found;
	logic [7:0]           sel_handle;
	logic [31:0]          sel_owner;
	logic [TIME_BITS-1:0] sel_deadline;
	logic                 sel_due;
	logic                 hx_valid;
	logic [TIME_BITS-1:0] hx_deadline;
	logic                 out_free;
	logic                 out_load;
	logic                 accept;
	logic                 x_last;
	logic [TIME_BITS-1:0] rem_val;
	logic [OUT_W-1:0]     resp_word;
	logic [OUT_W-1:0]     ext_word;

	assign out_free = !m_tvalid_q || m_tready;
	assign out_load = ((state_q == ST_RESP) || (state_q == ST_EXTRACT)) && out_free;
	assign s_tready = (state_q == ST_IDLE) || ((state_q == ST_RESP) && out_free);
	assign accept   = s_tvalid && s_tready;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tlast  = m_tlast_q;

	// chain
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		if (i == 0) begin : g_left_end
			assign lstat[i] = LEFT_END;
			assign l_dl[i]  = '0;
			assign l_hd[i]  = '0;
			assign l_ow[i]  = '0;
		end else begin : g_left
			assign lstat[i] = stat[i-1];
			assign l_dl[i]  = cell_dl[i-1];
			assign l_hd[i]  = cell_hd[i-1];
			assign l_ow[i]  = cell_ow[i-1];
		end
		if (i == DEPTH - 1) begin : g_right_end
			assign rstat[i] = RIGHT_END;
			assign r_dl[i]  = '0;
			assign r_hd[i]  = '0;
			assign r_ow[i]  = '0;
		end else begin : g_right
			assign rstat[i] = stat[i+1];
			assign r_dl[i]  = cell_dl[i+1];
			assign r_hd[i]  = cell_hd[i+1];
			assign r_ow[i]  = cell_ow[i+1];
		end

		sdtq_cell #(
			.TIME_BITS (TIME_BITS),
			.CAN_TAKE  (i < MAX_RESULTS)
		) u_cell (
			.clk          (clk),
			.arst_n       (arst_n),
			.op           (cell_op),
			.srch         (srch),
			.key_handle   (handle_s1),
			.key_owner    (owner_s1),
			.key_deadline (deadline_s1),
			.key_now      (now_s1),
			.l_stat       (lstat[i]),
			.l_deadline   (l_dl[i]),
			.l_handle     (l_hd[i]),
			.l_owner      (l_ow[i]),
			.r_stat       (rstat[i]),
			.r_deadline   (r_dl[i]),
			.r_handle     (r_hd[i]),
			.r_owner      (r_ow[i]),
			.stat         (stat[i]),
			.deadline     (cell_dl[i]),
			.handle       (cell_hd[i]),
			.owner        (cell_ow[i])
		);
	end

	always_comb begin
		srch.by_handle = (mode_s1 == MODE_ADD) || (mode_s1 == MODE_REM_HANDLE);
		srch.by_owner  = (mode_s1 == MODE_REM_OWNER) || (mode_s1 == MODE_REMAIN);
		srch.any       = (mode_s1 == MODE_POP) || (mode_s1 == MODE_POP_DUE);
	end

	always_comb begin
		sel_handle   = '0;
		sel_owner    = '0;
		sel_deadline = '0;
		sel_due      = 1'b0;
		hx_valid     = 1'b0;
		hx_deadline  = '0;
		for (int i = 0; i < DEPTH; i++) begin
			sel_handle   = sel_handle | ({8{stat[i].first}} & cell_hd[i]);
			sel_owner    = sel_owner | ({32{stat[i].first}} & cell_ow[i]);
			sel_deadline = sel_deadline | ({TIME_BITS{stat[i].first}} & cell_dl[i]);
			sel_due      = sel_due | (stat[i].first & stat[i].due);
			hx_valid     = hx_valid | stat[i].hsel;
			hx_deadline  = hx_deadline | ({TIME_BITS{stat[i].hsel}} & cell_dl[i]);
		end
	end

	assign found = stat[DEPTH-1].found;

	always_comb begin
		eval_op      = CELL_HOLD;
		eval_status  = STAT_NONE;
		eval_has     = 1'b0;
		eval_rem     = 1'b0;
		eval_extract = 1'b0;
		case (mode_s1)
			MODE_ADD: begin
				if (found) begin
					eval_status = STAT_DUP;
				end else if (stat[DEPTH-1].valid) begin
					eval_status = STAT_FULL;
				end else begin
					eval_status = STAT_OK;
					eval_op     = CELL_INSERT;
				end
			end
			MODE_REM_HANDLE, MODE_REM_OWNER, MODE_POP: begin
				if (found) begin
					eval_status = STAT_OK;
					eval_op     = CELL_REMOVE;
					eval_has    = 1'b1;
				end
			end
			MODE_POP_DUE: begin
				if (found && sel_due) begin
					eval_status = STAT_OK;
					eval_op     = CELL_REMOVE;
					eval_has    = 1'b1;
				end
			end
			MODE_EXTRACT: begin
				if (stat[0].tkn) begin
					eval_status  = STAT_OK;
					eval_op      = CELL_MARK;
					eval_extract = 1'b1;
				end
			end
			MODE_REMAIN: begin
				if (found) begin
					eval_status = STAT_OK;
					eval_has    = 1'b1;
					eval_rem    = 1'b1;
				end
			end
			default: ;
		endcase
	end

	always_comb begin
		if (state_q == ST_EVAL)
			cell_op = eval_op;
		else if ((state_q == ST_EXTRACT) && out_free)
			cell_op = CELL_SHIFT;
		else
			cell_op = CELL_HOLD;
	end

	assign rem_val = (res_rem_q && (now_s1 < res_deadline_q)) ?
		(res_deadline_q - now_s1) : '0;
	assign x_last  = !stat[1].tk;

	always_comb begin
		resp_word                        = '0;
		resp_word[1:0]                   = res_status_q;
		resp_word[O_HANDLE +: 8]         = res_handle_q;
		resp_word[O_OWNER +: 32]         = res_owner_q;
		resp_word[O_DL +: TIME_BITS]     = res_deadline_q;
		resp_word[O_REM +: TIME_BITS]    = rem_val;
		resp_word[O_HV]                  = stat[0].valid;
		resp_word[O_HDL +: TIME_BITS]    = stat[0].valid ? cell_dl[0] : '0;
	end

	always_comb begin
		ext_word                         = '0;
		ext_word[1:0]                    = STAT_OK;
		ext_word[O_HANDLE +: 8]          = cell_hd[0];
		ext_word[O_OWNER +: 32]          = cell_ow[0];
		ext_word[O_DL +: TIME_BITS]      = cell_dl[0];
		ext_word[O_HV]                   = hx_valid_q;
		ext_word[O_HDL +: TIME_BITS]     = hx_deadline_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			m_tvalid_q <= 1'b0;
		end else begin
			if (out_load)
				m_tvalid_q <= 1'b1;
			else if (m_tready)
				m_tvalid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept)
						state_q <= ST_EVAL;
				end
				ST_EVAL: begin
					state_q <= eval_extract ? ST_EXTRACT : ST_RESP;
				end
				ST_RESP: begin
					if (out_free)
						state_q <= accept ? ST_EVAL : ST_IDLE;
				end
				ST_EXTRACT: begin
					if (out_free && x_last)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mode_s1     <= mode_t'(s_tdata[2:0]);
			handle_s1   <= s_tdata[I_HANDLE +: 8];
			owner_s1    <= s_tdata[I_OWNER +: 32];
			deadline_s1 <= s_tdata[I_DL +: TIME_BITS];
			now_s1      <= s_tdata[I_NOW +: TIME_BITS];
		end
		if (state_q == ST_EVAL) begin
			res_status_q   <= eval_status;
			res_handle_q   <= eval_has ? sel_handle : '0;
			res_owner_q    <= eval_has ? sel_owner : '0;
			res_deadline_q <= eval_has ? sel_deadline : '0;
			res_rem_q      <= eval_rem;
			hx_valid_q     <= hx_valid;
			hx_deadline_q  <= hx_deadline;
		end
		if ((state_q == ST_RESP) && out_free) begin
			m_tdata_q <= resp_word;
			m_tlast_q <= 1'b1;
		end
		if ((state_q == ST_EXTRACT) && out_free) begin
			m_tdata_q <= ext_word;
			m_tlast_q <= x_last;
		end
	end

endmodule
`default_nettype wire

// File: design/sdtq_chk.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sdtq_chk: port checker for the sorted deadline timer queue
// Watches the request and result channels and is bound to the top level.
// ----------------------------------------------------------------------------
module sdtq_chk #(
	parameter int TIME_BITS = sdtq_pkg::TIME_BITS_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic s_tvalid,
	input wire logic s_tready,
	// mode, timer_handle, owner_key, deadline, now
	input wire logic [((43 + 2*TIME_BITS + 7) / 8) * 8 - 1:0] s_tdata,
	input wire logic m_tvalid,
	input wire logic m_tready,
	// status, out_handle, out_owner, out_deadline, remaining, head_valid,
	// head_deadline
	input wire logic [((43 + 3*TIME_BITS + 7) / 8) * 8 - 1:0] m_tdata,
	input wire logic m_tlast
);
	import sdtq_pkg::*;

	localparam int O_HV  = 42 + 2*TIME_BITS;
	localparam int O_HDL = 43 + 2*TIME_BITS;

	logic [1:0] status;
	assign status = m_tdata[1:0];

	a_one_request_per_step: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("request taken in back-to-back cycles");

	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("stalled result changed");

	a_empty_head_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[O_HV] |-> m_tdata[O_HDL +: TIME_BITS] == '0)
		else $error("empty queue reports nonzero head deadline");

	a_error_single: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (status != STAT_OK) |-> m_tlast && (m_tdata[O_HV-1:2] == '0))
		else $error("failed request carries timer data or is not last");

endmodule

bind sorted_deadline_timer_queue sdtq_chk #(.TIME_BITS(TIME_BITS)) u_sdtq_chk (.*);
`default_nettype wire

// File: tb/sv/sorted_deadline_timer_queue_tb.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sorted_deadline_timer_queue_tb: self-checking bench for the timer queue
// Requests come from a queue filled at start. A directed pass covers the
// empty, full, duplicate, equal-deadline and due/not-due edges; a random
// pass follows. Each accepted request runs through a local sorted-store
// predictor, and every result is checked field by field with random gaps
// and stalls on both channels.
// ----------------------------------------------------------------------------
module sorted_deadline_timer_queue_tb;
	import sdtq_pkg::*;

	localparam logic [2:0]  MODE_UNUSED = 3'd7;
	localparam logic [47:0] MAX48       = 48'hFFFF_FFFF_FFFF;

	typedef struct {
		logic [2:0]  mode;
		logic [7:0]  hnd;
		logic [31:0] owner;
		logic [47:0] dl;
		logic [47:0] now;
		bit          drain;
	} timer_req_t;

	typedef struct {
		logic [1:0]  status;
		logic [7:0]  hnd;
		logic [31:0] owner;
		logic [47:0] dl;
		logic [47:0] remaining;
		logic        head_valid;
		logic [47:0] head_dl;
		logic        fin;
	} timer_res_t;

	logic         clk      = 1'b0;
	logic         arst_n   = 1'b0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [143:0] s_tdata  = '0;
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [191:0] m_tdata;
	logic         m_tlast;

	timer_req_t  request_queue[$];
	timer_res_t  expected_results[$];

	logic [47:0] q_dl[DEPTH_DEF];
	logic [7:0]  q_hnd[DEPTH_DEF];
	logic [31:0] q_owner[DEPTH_DEF];
	int          q_cnt = 0;

	int          errors = 0;
	int          send_gap = 0;
	bit          send_burst = 0;
	int          stall_cnt = 0;
	bit          recv_burst = 0;

	sorted_deadline_timer_queue i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		#10_000_000;
		$display("sorted_deadline_timer_queue test failed");
		$finish;
	end

	function automatic logic [47:0] rand48();
		logic [63:0] v;
		v = {$urandom, $urandom};
		return v[47:0];
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 65)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(5, 30);
	endfunction

	function automatic timer_res_t blank_res();
		timer_res_t r;
		r.status     = STAT_OK;
		r.hnd        = '0;
		r.owner      = '0;
		r.dl         = '0;
		r.remaining  = '0;
		r.head_valid = 1'b0;
		r.head_dl    = '0;
		r.fin        = 1'b0;
		return r;
	endfunction

	function automatic int find_slot(bit by_owner, logic [7:0] hnd, logic [31:0] owner);
		for (int i = 0; i < q_cnt; i++)
			if (by_owner ? (q_owner[i] == owner) : (q_hnd[i] == hnd))
				return i;
		return -1;
	endfunction

	// report the timer at idx, then close the gap behind it
	function automatic timer_res_t leave_at(int idx);
		timer_res_t r;
		r       = blank_res();
		r.hnd   = q_hnd[idx];
		r.owner = q_owner[idx];
		r.dl    = q_dl[idx];
		for (int i = idx; i + 1 < q_cnt; i++) begin
			q_dl[i]    = q_dl[i + 1];
			q_hnd[i]   = q_hnd[i + 1];
			q_owner[i] = q_owner[i + 1];
		end
		q_cnt--;
		return r;
	endfunction

	task automatic apply_request(input timer_req_t r);
		timer_res_t step_res[$];
		timer_res_t one;
		int idx;
		int pos;
		one = blank_res();
		case (r.mode)
			MODE_ADD: begin
				if (find_slot(0, r.hnd, r.owner) >= 0) begin
					one.status = STAT_DUP;
				end else if (q_cnt >= DEPTH_DEF) begin
					one.status = STAT_FULL;
				end else begin
					pos = 0;
					while (pos < q_cnt && q_dl[pos] <= r.dl)
						pos++;
					for (int i = q_cnt; i > pos; i--) begin
						q_dl[i]    = q_dl[i - 1];
						q_hnd[i]   = q_hnd[i - 1];
						q_owner[i] = q_owner[i - 1];
					end
					q_dl[pos]    = r.dl;
					q_hnd[pos]   = r.hnd;
					q_owner[pos] = r.owner;
					q_cnt++;
				end
				step_res.push_back(one);
			end
			MODE_REM_HANDLE, MODE_REM_OWNER: begin
				idx = find_slot(r.mode == MODE_REM_OWNER, r.hnd, r.owner);
				if (idx < 0) begin
					one.status = STAT_NONE;
					step_res.push_back(one);
				end else begin
					step_res.push_back(leave_at(idx));
				end
			end
			MODE_POP, MODE_POP_DUE: begin
				if (q_cnt == 0 || (r.mode == MODE_POP_DUE && !(q_dl[0] < r.now))) begin
					one.status = STAT_NONE;
					step_res.push_back(one);
				end else begin
					step_res.push_back(leave_at(0));
				end
			end
			MODE_EXTRACT: begin
				while (step_res.size() < MAX_RESULTS && q_cnt > 0 && q_dl[0] < r.now)
					step_res.push_back(leave_at(0));
				if (step_res.size() == 0) begin
					one.status = STAT_NONE;
					step_res.push_back(one);
				end
			end
			MODE_REMAIN: begin
				idx = find_slot(1, r.hnd, r.owner);
				if (idx < 0) begin
					one.status = STAT_NONE;
				end else begin
					one.hnd       = q_hnd[idx];
					one.owner     = q_owner[idx];
					one.dl        = q_dl[idx];
					one.remaining = (r.now < q_dl[idx]) ? q_dl[idx] - r.now : '0;
				end
				step_res.push_back(one);
			end
			default: begin
				one.status = STAT_NONE;
				step_res.push_back(one);
			end
		endcase
		foreach (step_res[k]) begin
			step_res[k].head_valid = (q_cnt > 0);
			step_res[k].head_dl    = (q_cnt > 0) ? q_dl[0] : '0;
			step_res[k].fin        = (k == step_res.size() - 1);
			expected_results.push_back(step_res[k]);
		end
	endtask

	task automatic report_error(input string msg);
		$display("ERROR at %0t: %s", $realtime, msg);
		errors++;
	endtask

	task automatic check_field(input string name, input logic [63:0] got, input logic [63:0] want);
		if (got !== want)
			report_error($sformatf("%s got %0h expected %0h", name, got, want));
	endtask

	task automatic push_req(input logic [2:0] mode, input logic [7:0] hnd,
		input logic [31:0] owner, input logic [47:0] dl, input logic [47:0] now,
		input bit drain);
		timer_req_t r;
		r.mode  = mode;
		r.hnd   = hnd;
		r.owner = owner;
		r.dl    = dl;
		r.now   = now;
		r.drain = drain;
		request_queue.push_back(r);
	endtask

	always @(posedge clk or negedge arst_n) begin
		logic         nv;
		logic [143:0] nd;
		timer_req_t   head;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= '0;
		end else begin
			nv = s_tvalid;
			nd = s_tdata;
			if (s_tvalid && s_tready) begin
				apply_request(request_queue.pop_front());
				send_gap = send_burst ? 0 : pick_gap();
				if ($urandom_range(0, 29) == 0)
					send_burst = !send_burst;
			end
			if (!(s_tvalid && !s_tready)) begin
				nv = 1'b0;
				if (send_gap > 0) begin
					send_gap--;
				end else if (request_queue.size() > 0) begin
					head = request_queue[0];
					if (!head.drain || expected_results.size() == 0) begin
						nv = 1'b1;
						nd = {5'd0, head.now, head.dl, head.owner, head.hnd, head.mode};
					end
				end
			end
			s_tvalid <= nv;
			s_tdata  <= nd;
		end
	end

	always @(posedge clk or negedge arst_n) begin
		timer_res_t want;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (expected_results.size() == 0) begin
					report_error($sformatf("result with nothing expected, data %0h", m_tdata));
				end else begin
					want = expected_results.pop_front();
					check_field("status", m_tdata[1:0], want.status);
					check_field("out_handle", m_tdata[9:2], want.hnd);
					check_field("out_owner", m_tdata[41:10], want.owner);
					check_field("out_deadline", m_tdata[89:42], want.dl);
					check_field("remaining", m_tdata[137:90], want.remaining);
					check_field("head_valid", m_tdata[138], want.head_valid);
					check_field("head_deadline", m_tdata[186:139], want.head_dl);
					check_field("last", m_tlast, want.fin);
				end
				stall_cnt = recv_burst ? 0 : pick_gap();
				if ($urandom_range(0, 29) == 0)
					recv_burst = !recv_burst;
			end else if (stall_cnt == 0 && !recv_burst && $urandom_range(0, 7) == 0) begin
				stall_cnt = pick_gap();
			end
			if (stall_cnt > 0) begin
				stall_cnt--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	initial begin
		logic [31:0] owner_pool[8];
		logic [47:0] gen_now;
		logic [47:0] dl;
		logic [47:0] now;
		logic [7:0]  hnd;
		logic [31:0] owner;
		logic [2:0]  mode;
		int          pick;
		int          add_pct;

		// empty queue
		push_req(MODE_POP, 8'd0, 32'd0, 48'd0, 48'd0, 0);
		push_req(MODE_EXTRACT, 8'd0, 32'd0, 48'd0, MAX48, 0);
		push_req(MODE_UNUSED, 8'hFF, 32'hFFFF_FFFF, MAX48, MAX48, 0);
		push_req(MODE_REMAIN, 8'd3, 32'h1234_5678, 48'd0, 48'd5, 0);

		// fill to capacity with extremes and a run of equal deadlines
		push_req(MODE_ADD, 8'd0, 32'd0, 48'd0, 48'd0, 0);
		push_req(MODE_ADD, 8'hFF, 32'hFFFF_FFFF, MAX48, 48'd0, 0);
		push_req(MODE_ADD, 8'd10, 32'hA5A5_0010, 48'd500, 48'd0, 0);
		push_req(MODE_ADD, 8'd11, 32'hA5A5_0011, 48'd500, 48'd0, 0);
		push_req(MODE_ADD, 8'd12, 32'hA5A5_0012, 48'd500, 48'd0, 0);
		for (int i = 0; i < 11; i++)
			push_req(MODE_ADD, 8'(20 + i), $urandom, 48'($urandom_range(1, 5000)), 48'd0, 0);
		push_req(MODE_ADD, 8'd0, 32'h5555_AAAA, 48'd7, 48'd0, 0);
		push_req(MODE_ADD, 8'd100, 32'h0BAD_0001, 48'd7, 48'd0, 0);

		push_req(MODE_POP_DUE, 8'd0, 32'd0, 48'd0, 48'd0, 0);
		push_req(MODE_REMAIN, 8'd0, 32'hA5A5_0011, 48'd0, 48'd100, 0);
		push_req(MODE_REMAIN, 8'd0, 32'hFFFF_FFFF, 48'd0, MAX48, 0);
		push_req(MODE_POP_DUE, 8'd0, 32'd0, 48'd0, 48'd1, 0);
		push_req(MODE_REM_HANDLE, 8'hFF, 32'd0, 48'd0, 48'd0, 0);
		push_req(MODE_REM_OWNER, 8'd0, 32'hA5A5_0012, 48'd0, 48'd0, 0);
		push_req(MODE_EXTRACT, 8'd0, 32'd0, 48'd0, MAX48, 1);

		foreach (owner_pool[i])
			owner_pool[i] = $urandom;
		gen_now = 48'd1000;
		for (int i = 0; i < 300; i++) begin
			add_pct = ((i / 48) % 2 == 0) ? 60 : 25;
			gen_now += 48'($urandom_range(0, 60));
			if ($urandom_range(0, 49) == 0)
				gen_now = rand48();
			hnd   = ($urandom_range(0, 4) != 0) ? 8'($urandom_range(0, 23)) : 8'($urandom);
			owner = ($urandom_range(0, 3) != 0) ? owner_pool[$urandom_range(0, 7)] : $urandom;
			pick  = $urandom_range(0, 99);
			if (pick < 85)
				dl = gen_now + 48'(10 * $urandom_range(0, 30));
			else if (pick < 95)
				dl = rand48();
			else
				dl = $urandom_range(0, 1) ? MAX48 : 48'd0;
			now = ($urandom_range(0, 9) != 0) ? gen_now : rand48();
			pick = $urandom_range(0, 99);
			if (pick < add_pct)
				mode = MODE_ADD;
			else if (pick >= 98)
				mode = MODE_UNUSED;
			else
				case ($urandom_range(0, 5))
					0: mode = MODE_REM_HANDLE;
					1: mode = MODE_REM_OWNER;
					2: mode = MODE_POP;
					3: mode = MODE_POP_DUE;
					4: mode = MODE_EXTRACT;
					default: mode = MODE_REMAIN;
				endcase
			push_req(mode, hnd, owner, dl, now, $urandom_range(0, 39) == 0);
		end

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		while (request_queue.size() != 0 || expected_results.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
		if (errors == 0)
			$display("sorted_deadline_timer_queue test passed");
		else
			$display("sorted_deadline_timer_queue test failed");
		$finish;
	end

endmodule
`default_nettype wire
